### src/ccnr_pkg.sv
package ccnr_pkg;

  // Field and counter widths
  localparam int unsigned MAX_SIZE = 2048;
  localparam int unsigned SIZE_W   = $clog2(MAX_SIZE + 1);     // 1..MAX_SIZE
  localparam int unsigned POS_W    = $clog2(MAX_SIZE);         // 0..MAX_SIZE-1
  localparam int unsigned OFF_W    = $clog2(MAX_SIZE / 2);     // crop offset
  localparam int unsigned ACC_W    = 2 * POS_W + 1;            // up to MAX_SIZE^2
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned CHAN_W   = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(320);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_TARGET_WIDTH  = 3'd2,
    REG_TARGET_HEIGHT = 3'd3
  } cfg_reg_t;

  // Effective frame geometry, derived from the four registers
  typedef struct packed {
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [SIZE_W-1:0] tw;
    logic [SIZE_W-1:0] th;
    logic [OFF_W-1:0]  off;
  } geom_t;

  typedef logic [31:0][CHAN_W-1:0] exp5_tab_t;
  typedef logic [63:0][CHAN_W-1:0] exp6_tab_t;

  // Clamp a register value to 1..MAX_SIZE
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > MAX_SIZE) begin
      r = SIZE_W'(MAX_SIZE);
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

  function automatic geom_t calc_geom(input logic [CFG_W-1:0] sw,
                                      input logic [CFG_W-1:0] sh,
                                      input logic [CFG_W-1:0] tw,
                                      input logic [CFG_W-1:0] th);
    geom_t             g;
    logic [SIZE_W-1:0] t;
    logic [SIZE_W-1:0] diff;
    g.w  = eff_size(sw);
    g.h  = eff_size(sh);
    t    = eff_size(tw);
    g.tw = (t > g.h) ? g.h : t;
    t    = eff_size(th);
    g.th = (t > g.h) ? g.h : t;
    diff = g.w - g.h;
    g.off = (g.w > g.h) ? OFF_W'(diff >> 1) : '0;
    return g;
  endfunction

  localparam geom_t GEOM_RESET = calc_geom(CFG_RESET, CFG_RESET, CFG_RESET, CFG_RESET);

  // Channel expansion tables: floor(c * 255 / max), worked out at elaboration
  function automatic exp5_tab_t build_exp5();
    exp5_tab_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = CHAN_W'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic exp6_tab_t build_exp6();
    exp6_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = CHAN_W'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam exp5_tab_t EXP5_TAB = build_exp5();
  localparam exp6_tab_t EXP6_TAB = build_exp6();

endpackage

### src/ccnr_if.sv
// Source pixel channel
interface ccnr_pix_if;
  logic                         valid;
  logic                         ready;
  logic [ccnr_pkg::PIX_W-1:0]   pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// Resized pixel channel
interface ccnr_rgb_if;
  logic                                valid;
  logic                                ready;
  logic signed [ccnr_pkg::CHAN_W-1:0]  red;
  logic signed [ccnr_pkg::CHAN_W-1:0]  green;
  logic signed [ccnr_pkg::CHAN_W-1:0]  blue;
  logic                                row_end;
  logic                                frame_end;

  modport source (output valid, output red, output green, output blue,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input row_end, input frame_end, output ready);
endinterface

### src/center_crop_nearest_resize_rgb565_top.sv
// Channel   Dir  Payload                                 Transfer
// in_pix    in   pixel[15:0] RGB565                      valid & ready
// out_px    out  red, green, blue (s8), row_end, frame_end valid & ready
// cfg_*     in   cfg_index[2:0], cfg_wdata[11:0]         cfg_we
//
// One source pixel per cycle while in_pix.ready is high; a picked pixel appears at
// the output in the cycle after its transfer, through a single output register.
// in_pix.ready drops only while that register is full and not being taken.
// Synchronous active-low reset loads 320 into all four registers and starts
// a new frame; any register write also restarts the frame.
module center_crop_nearest_resize_rgb565_top (
  input  logic                            clk,
  input  logic                            rst_n,
  ccnr_pix_if.sink                        in_pix,
  ccnr_rgb_if.source                      out_px,
  input  logic                            cfg_we,
  input  logic [ccnr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccnr_pkg::CFG_W-1:0]      cfg_wdata
);
  import ccnr_pkg::*;

  // Configuration and derived geometry
  logic [CFG_W-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic [CFG_W-1:0] src_w_nxt, src_h_nxt, tgt_w_nxt, tgt_h_nxt;
  geom_t            geom_r;
  geom_t            geom_nxt;
  logic             cfg_hit;

  // Frame position state
  logic [POS_W-1:0]  src_col_r, src_col_nxt;
  logic [POS_W-1:0]  src_row_r, src_row_nxt;
  logic [ACC_W-1:0]  col_acc_r, col_acc_nxt;
  logic [ACC_W-1:0]  col_bound_r, col_bound_nxt;
  logic [ACC_W-1:0]  row_acc_r, row_acc_nxt;
  logic [ACC_W-1:0]  row_bound_r, row_bound_nxt;
  logic [SIZE_W-1:0] out_col_r, out_col_nxt;
  logic [SIZE_W-1:0] out_row_r, out_row_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [CHAN_W-1:0] red_r, green_r, blue_r;
  logic                     row_end_r, frame_end_r;

  // Per-pixel decisions
  logic              in_xfer;
  logic [SIZE_W-1:0] col_ext;
  logic [SIZE_W-1:0] crop_pos;
  logic              in_crop;
  logic              row_sel;
  logic              col_sel;
  logic              emit;
  logic              last_col;
  logic              last_row;
  logic              re;
  logic              fe;

  // Register writes
  always_comb begin
    src_w_nxt = src_w_r;
    src_h_nxt = src_h_r;
    tgt_w_nxt = tgt_w_r;
    tgt_h_nxt = tgt_h_r;
    cfg_hit   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  begin src_w_nxt = cfg_wdata; cfg_hit = 1'b1; end
        REG_SOURCE_HEIGHT: begin src_h_nxt = cfg_wdata; cfg_hit = 1'b1; end
        REG_TARGET_WIDTH:  begin tgt_w_nxt = cfg_wdata; cfg_hit = 1'b1; end
        REG_TARGET_HEIGHT: begin tgt_h_nxt = cfg_wdata; cfg_hit = 1'b1; end
        default:           cfg_hit = 1'b0;
      endcase
    end
    geom_nxt = calc_geom(src_w_nxt, src_h_nxt, tgt_w_nxt, tgt_h_nxt);
  end

  // Accept while the output register is empty or being drained
  assign in_pix.ready = !out_valid_r || out_px.ready;
  assign in_xfer      = in_pix.valid && in_pix.ready;

  // Crop window, selection and end marks
  always_comb begin
    col_ext  = {1'b0, src_col_r};
    crop_pos = col_ext - SIZE_W'(geom_r.off);
    in_crop  = (col_ext >= SIZE_W'(geom_r.off)) && (crop_pos < geom_r.h);
    row_sel  = (row_acc_r < row_bound_r) && (out_row_r < geom_r.th);
    col_sel  = in_crop && (col_acc_r < col_bound_r) && (out_col_r < geom_r.tw);
    emit     = row_sel && col_sel;
    re       = (out_col_r == geom_r.tw - SIZE_W'(1));
    fe       = re && (out_row_r == geom_r.th - SIZE_W'(1));
    last_col = (col_ext + SIZE_W'(1)) >= geom_r.w;
    last_row = ({1'b0, src_row_r} + SIZE_W'(1)) >= geom_r.h;
  end

  // Advance the frame position for one source pixel
  always_comb begin
    src_col_nxt   = src_col_r;
    src_row_nxt   = src_row_r;
    col_acc_nxt   = col_acc_r;
    col_bound_nxt = col_bound_r;
    row_acc_nxt   = row_acc_r;
    row_bound_nxt = row_bound_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    if (in_crop) begin
      col_bound_nxt = col_bound_r + ACC_W'(geom_r.tw);
      if (col_sel) begin
        col_acc_nxt = col_acc_r + ACC_W'(geom_r.h);
      end
    end
    if (emit) begin
      out_col_nxt = out_col_r + SIZE_W'(1);
    end
    if (last_col) begin
      if (last_row) begin
        src_row_nxt   = '0;
        row_acc_nxt   = '0;
        row_bound_nxt = ACC_W'(geom_r.th);
        out_row_nxt   = '0;
      end else begin
        src_row_nxt   = src_row_r + POS_W'(1);
        row_bound_nxt = row_bound_r + ACC_W'(geom_r.th);
        if (row_sel) begin
          row_acc_nxt = row_acc_r + ACC_W'(geom_r.h);
          out_row_nxt = out_row_r + SIZE_W'(1);
        end
      end
      src_col_nxt   = '0;
      col_acc_nxt   = '0;
      col_bound_nxt = ACC_W'(geom_r.tw);
      out_col_nxt   = '0;
    end else begin
      src_col_nxt = src_col_r + POS_W'(1);
    end
  end

  // Output valid: load on transfer, drop once taken
  always_comb begin
    if (in_xfer) begin
      out_valid_nxt = emit;
    end else if (out_px.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r     <= CFG_RESET;
      src_h_r     <= CFG_RESET;
      tgt_w_r     <= CFG_RESET;
      tgt_h_r     <= CFG_RESET;
      geom_r      <= GEOM_RESET;
      src_col_r   <= '0;
      src_row_r   <= '0;
      col_acc_r   <= '0;
      col_bound_r <= ACC_W'(GEOM_RESET.tw);
      row_acc_r   <= '0;
      row_bound_r <= ACC_W'(GEOM_RESET.th);
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_hit) begin
        src_w_r     <= src_w_nxt;
        src_h_r     <= src_h_nxt;
        tgt_w_r     <= tgt_w_nxt;
        tgt_h_r     <= tgt_h_nxt;
        geom_r      <= geom_nxt;
        src_col_r   <= '0;
        src_row_r   <= '0;
        col_acc_r   <= '0;
        col_bound_r <= ACC_W'(geom_nxt.tw);
        row_acc_r   <= '0;
        row_bound_r <= ACC_W'(geom_nxt.th);
        out_col_r   <= '0;
        out_row_r   <= '0;
      end else if (in_xfer) begin
        src_col_r   <= src_col_nxt;
        src_row_r   <= src_row_nxt;
        col_acc_r   <= col_acc_nxt;
        col_bound_r <= col_bound_nxt;
        row_acc_r   <= row_acc_nxt;
        row_bound_r <= row_bound_nxt;
        out_col_r   <= out_col_nxt;
        out_row_r   <= out_row_nxt;
      end
    end
  end

  // Output payload: expand each channel and flip the sign bit
  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      red_r       <= EXP5_TAB[in_pix.pixel[15:11]] ^ CHAN_W'(128);
      green_r     <= EXP6_TAB[in_pix.pixel[10:5]] ^ CHAN_W'(128);
      blue_r      <= EXP5_TAB[in_pix.pixel[4:0]] ^ CHAN_W'(128);
      row_end_r   <= re;
      frame_end_r <= fe;
    end
  end

  assign out_px.valid     = out_valid_r;
  assign out_px.red       = red_r;
  assign out_px.green     = green_r;
  assign out_px.blue      = blue_r;
  assign out_px.row_end   = row_end_r;
  assign out_px.frame_end = frame_end_r;

endmodule

### src/ccnr_checker.sv
module ccnr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [ccnr_pkg::CHAN_W-1:0] red,
  input logic signed [ccnr_pkg::CHAN_W-1:0] green,
  input logic signed [ccnr_pkg::CHAN_W-1:0] blue,
  input logic                             row_end,
  input logic                             frame_end
);
  import ccnr_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
      && $stable(blue) && $stable(row_end) && $stable(frame_end))
    else $error("stalled result changed");

  // Stall the input while a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output full");

  // Ready the input whenever the output register is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Every new result comes from an input transfer
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
    else $error("result without input transfer");

  // A frame end is also a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

endmodule

bind center_crop_nearest_resize_rgb565_top ccnr_checker u_ccnr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_px.valid),
  .out_ready (out_px.ready),
  .red       (out_px.red),
  .green     (out_px.green),
  .blue      (out_px.blue),
  .row_end   (out_px.row_end),
  .frame_end (out_px.frame_end)
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import ccnr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_ITEMS  = 1450;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS   = 40;

  // Index outside the register file, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

  typedef struct packed {
    logic signed [CHAN_W-1:0] red;
    logic signed [CHAN_W-1:0] green;
    logic signed [CHAN_W-1:0] blue;
    logic                     row_end;
    logic                     frame_end;
  } rgb_px_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  ccnr_pix_if in_pix ();
  ccnr_rgb_if out_px ();

  center_crop_nearest_resize_rgb565_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .out_px    (out_px),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register shadow and effective geometry
  logic [CFG_W-1:0] sw_reg, sh_reg, tw_reg, th_reg;
  int unsigned      geo_w, geo_h, geo_tw, geo_th, crop_off;

  // Position in the source and output frames
  logic [POS_W-1:0] src_col, src_row, dst_col, dst_row;
  logic [ACC_W-1:0] col_acc, col_lim, row_acc, row_lim;

  rgb_px_t     awaited_rgb[$];
  rgb_px_t     next_rgb;
  int unsigned errors;
  int unsigned random_items;
  int unsigned cycle_cnt;
  int unsigned ready_hold;
  bit          src_steady;
  bit          snk_steady;

  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIZE) return MAX_SIZE;
    return 32'(v);
  endfunction

  // Recompute geometry from the shadow registers and restart the frame walk
  function automatic void rewind_frame();
    geo_w  = clamp_size(sw_reg);
    geo_h  = clamp_size(sh_reg);
    geo_tw = clamp_size(tw_reg);
    geo_th = clamp_size(th_reg);
    if (geo_tw > geo_h) geo_tw = geo_h;
    if (geo_th > geo_h) geo_th = geo_h;
    crop_off = (geo_w > geo_h) ? (geo_w - geo_h) / 2 : 0;
    src_col = '0;
    src_row = '0;
    dst_col = '0;
    dst_row = '0;
    col_acc = '0;
    row_acc = '0;
    col_lim = ACC_W'(geo_tw);
    row_lim = ACC_W'(geo_th);
  endfunction

  // Scale a channel to 0..255 and shift it to the signed range
  function automatic logic signed [CHAN_W-1:0] to_chan(input int unsigned c,
                                                       input int unsigned cmax);
    int scaled;
    scaled = int'((c * 255) / cmax) - 128;
    return CHAN_W'(scaled);
  endfunction

  // Advance the frame walk by one source pixel, queue the output if picked
  task automatic pick_pixel(input logic [PIX_W-1:0] pix);
    logic    row_pick;
    logic    col_pick;
    rgb_px_t px;
    row_pick = (row_acc < row_lim) && (dst_row < geo_th);
    col_pick = 1'b0;
    if (src_col >= crop_off && src_col - crop_off < geo_h) begin
      col_pick = (col_acc < col_lim) && (dst_col < geo_tw);
      if (col_pick) col_acc += ACC_W'(geo_h);
      col_lim += ACC_W'(geo_tw);
    end
    if (row_pick && col_pick) begin
      px.red       = to_chan(32'(pix[15:11]), 31);
      px.green     = to_chan(32'(pix[10:5]), 63);
      px.blue      = to_chan(32'(pix[4:0]), 31);
      px.row_end   = (dst_col == geo_tw - 1);
      px.frame_end = px.row_end && (dst_row == geo_th - 1);
      awaited_rgb.push_back(px);
      dst_col++;
    end
    if (src_col + 1 >= geo_w) begin
      if (src_row + 1 >= geo_h) begin
        rewind_frame();
      end else begin
        if (row_pick) begin
          row_acc += ACC_W'(geo_h);
          dst_row++;
        end
        row_lim += ACC_W'(geo_th);
        src_row++;
        src_col = '0;
        col_acc = '0;
        col_lim = ACC_W'(geo_tw);
        dst_col = '0;
      end
    end else begin
      src_col++;
    end
  endtask

  // Write one register; leaves cfg_we high so writes can follow back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    bit mapped;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    mapped = 1'b1;
    case (idx)
      REG_SOURCE_WIDTH:  sw_reg = val;
      REG_SOURCE_HEIGHT: sh_reg = val;
      REG_TARGET_WIDTH:  tw_reg = val;
      REG_TARGET_HEIGHT: th_reg = val;
      default:           mapped = 1'b0;
    endcase
    if (mapped) rewind_frame();
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th);
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
    write_reg(REG_TARGET_WIDTH, tw);
    write_reg(REG_TARGET_HEIGHT, th);
    cfg_we <= 1'b0;
  endtask

  // Offer one source pixel after a random gap and hold it until the transfer
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.pixel <= pix;
    do @(posedge clk); while (in_pix.ready !== 1'b1);
    pick_pixel(pix);
    @(negedge clk);
  endtask

  // Drop valid, wait for every queued output, then let the pipeline empty
  task automatic settle();
    int unsigned waited;
    in_pix.valid <= 1'b0;
    waited = 0;
    while (awaited_rgb.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (awaited_rgb.size() != 0) begin
      errors += awaited_rgb.size();
      $display("%0t missing %0d results: expected %p actual none",
               $time, awaited_rgb.size(), awaited_rgb[0]);
      awaited_rgb.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic signed [CHAN_W-1:0] want,
                               input logic signed [CHAN_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  function automatic logic [CFG_W-1:0] extreme_size();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(MAX_SIZE);
      3:       return '1;
      default: return CFG_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Check each output transfer against the oldest queued pixel
  always @(posedge clk) begin
    if (rst_n && out_px.valid && out_px.ready) begin
      if (awaited_rgb.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t unexpected transfer: expected none actual r %0d g %0d b %0d re %0b fe %0b",
                   $time, out_px.red, out_px.green, out_px.blue, out_px.row_end,
                   out_px.frame_end);
      end else begin
        next_rgb = awaited_rgb.pop_front();
        compare_field("red", next_rgb.red, out_px.red);
        compare_field("green", next_rgb.green, out_px.green);
        compare_field("blue", next_rgb.blue, out_px.blue);
        compare_field("row_end", CHAN_W'(next_rgb.row_end), CHAN_W'(out_px.row_end));
        compare_field("frame_end", CHAN_W'(next_rgb.frame_end), CHAN_W'(out_px.frame_end));
      end
      ready_hold = snk_steady ? 0 : $urandom_range(0, 16);
    end
  end

  // Stall the output side after each transfer, holding ready low until ready_hold counts down to zero
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      out_px.ready <= 1'b0;
      ready_hold--;
    end else begin
      out_px.ready <= 1'b1;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Reset geometry: every pixel of the first row comes out; channel corners
  task automatic test_channel_extremes();
    logic [PIX_W-1:0] corners [6];
    corners = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h8410};
    foreach (corners[i]) send_pixel(corners[i]);
    settle();
  endtask

  // Source narrower than the crop: outputs past the last column never appear
  task automatic test_narrow_source();
    set_geometry(12'd2, 12'd3, 12'd3, 12'd2);
    repeat (6) send_pixel(PIX_W'($urandom));
    settle();
  endtask

  // Target larger than the source height is cut back to it
  task automatic test_upscale_request();
    src_steady = 1'b1;
    snk_steady = 1'b1;
    set_geometry(12'd5, 12'd2, 12'd7, 12'd7);
    repeat (10) send_pixel(PIX_W'($urandom));
    settle();
    src_steady = 1'b0;
    snk_steady = 1'b0;
  endtask

  // Zero and oversized registers, then a write to an unmapped index mid-frame
  task automatic test_size_clamps();
    set_geometry('0, '1, CFG_W'(MAX_SIZE), '0);
    repeat (2) send_pixel(PIX_W'($urandom));
    settle();
    write_reg(REG_UNMAPPED, 12'hABC);
    cfg_we <= 1'b0;
    repeat (2) send_pixel(PIX_W'($urandom));
    settle();
  endtask

  // Mostly whole small frames with random content, some huge partial frames
  task automatic test_random_frames();
    int unsigned w, h, frame, n, first;
    while (random_items < RANDOM_ITEMS) begin
      src_steady = ($urandom_range(0, 4) == 0);
      snk_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) begin
        set_geometry(extreme_size(), extreme_size(), extreme_size(), extreme_size());
        n = $urandom_range(10, 40);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 10);
        set_geometry(CFG_W'(w), CFG_W'(h), CFG_W'($urandom_range(0, h + 2)),
                     CFG_W'($urandom_range(0, h + 2)));
        frame = w * h;
        n = $urandom_range(1, 2) * frame;
        if ($urandom_range(0, 3) == 0) n += $urandom_range(0, frame - 1);
      end
      first = $urandom_range(0, n);
      repeat (first) send_pixel(PIX_W'($urandom));
      // Drop a stray write partway through; the frame must carry on
      if ($urandom_range(0, 7) == 0) begin
        settle();
        write_reg(REG_UNMAPPED, CFG_W'($urandom));
        cfg_we <= 1'b0;
      end
      repeat (n - first) send_pixel(PIX_W'($urandom));
      settle();
      random_items += n;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_pix.valid = 1'b0;
    in_pix.pixel = '0;
    out_px.ready = 1'b0;
    errors       = 0;
    random_items = 0;
    cycle_cnt    = 0;
    ready_hold   = 0;
    src_steady   = 1'b0;
    snk_steady   = 1'b0;
    sw_reg       = CFG_RESET;
    sh_reg       = CFG_RESET;
    tw_reg       = CFG_RESET;
    th_reg       = CFG_RESET;
    rewind_frame();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_channel_extremes();
    test_narrow_source();
    test_upscale_request();
    test_size_clamps();
    test_random_frames();
    settle();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
